>>> rtl/core/pc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pc_pkg: shared types and constants
// State encodings, status codes and fixed-point constants for the
// correlation core.
// ----------------------------------------------------------------------------
package pc_pkg;

    localparam int CORR_W = 16;
    localparam int QBITS  = 16;
    localparam int QFRAC  = 15;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ZERO_VAR = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

    localparam logic [QBITS-1:0] Q_ONE = 16'h8000;
    localparam logic [QBITS-1:0] Q_MAX = 16'h7fff;

    typedef enum logic [1:0] {
        T_IDLE,
        T_ACC,
        T_FIN,
        T_OUT
    } t_top_state;

    typedef enum logic [2:0] {
        F_IDLE,
        F_SETUP,
        F_MUL,
        F_STORE,
        F_SRCH0,
        F_SRCH1,
        F_SRCH2,
        F_SRCH3
    } t_fin_state;

    typedef enum logic [2:0] {
        JOB_N_XY,
        JOB_X_Y,
        JOB_N_XX,
        JOB_X_X,
        JOB_N_YY,
        JOB_Y_Y,
        JOB_VXY,
        JOB_NUM2
    } t_job;

    typedef enum logic [1:0] {
        PH_XX,
        PH_YY,
        PH_XY
    } t_phase;

    typedef struct packed {
        logic              done;
        logic [CORR_W-1:0] corr;
        logic [1:0]        status;
    } t_fin_result;

endpackage

>>> rtl/core/pc_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pc_accum: sample accumulator
// Keeps the sample count and the exact sums of x, y, x*x, y*y and x*y.
// The three products of a pair go through one multiplier in turn.
// ----------------------------------------------------------------------------
module pc_accum import pc_pkg::*; #(
    parameter int SB          = 16,
    parameter int CW          = 13,
    parameter int SXW         = 29,
    parameter int SQW         = 45,
    parameter int MAX_SAMPLES = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_clear,
    input  logic signed [SB-1:0]  i_x,
    input  logic signed [SB-1:0]  i_y,
    output logic                  o_done,
    output logic        [CW-1:0]  o_count,
    output logic signed [SXW-1:0] o_sum_x,
    output logic signed [SXW-1:0] o_sum_y,
    output logic signed [SQW-1:0] o_sum_xx,
    output logic signed [SQW-1:0] o_sum_yy,
    output logic signed [SQW-1:0] o_sum_xy,
    output logic                  o_overflow
);

    logic signed [SB-1:0]   r_x, r_y;
    logic                   r_run, r_add, r_done, r_ovf;
    t_phase                 r_ph;
    logic        [CW-1:0]   r_count;
    logic signed [SXW-1:0]  r_sx, r_sy;
    logic signed [SQW-1:0]  r_sxx, r_syy, r_sxy;

    logic signed [SB-1:0]   m_a, m_b;
    logic signed [2*SB-1:0] prod;
    logic signed [SQW-1:0]  prod_ext, sel_sum, new_sum;
    logic                   room;

    assign room = (r_count < CW'(MAX_SAMPLES));

    always_comb begin
        m_a = (r_ph == PH_YY) ? r_y : r_x;
        m_b = (r_ph == PH_XX) ? r_x : r_y;
        prod = m_a * m_b;
        prod_ext = {{(SQW-2*SB){prod[2*SB-1]}}, prod};
        case (r_ph)
            PH_XX:   sel_sum = r_sxx;
            PH_YY:   sel_sum = r_syy;
            PH_XY:   sel_sum = r_sxy;
            default: sel_sum = r_sxy;
        endcase
        new_sum = sel_sum + prod_ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_run   <= 1'b0;
            r_add   <= 1'b0;
            r_done  <= 1'b0;
            r_ovf   <= 1'b0;
            r_ph    <= PH_XX;
            r_count <= '0;
            r_sx    <= '0;
            r_sy    <= '0;
            r_sxx   <= '0;
            r_syy   <= '0;
            r_sxy   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x   <= i_x;
                r_y   <= i_y;
                r_run <= 1'b1;
                r_ph  <= PH_XX;
                r_add <= room;
                if (room) begin
                    r_sx    <= r_sx + {{(SXW-SB){i_x[SB-1]}}, i_x};
                    r_sy    <= r_sy + {{(SXW-SB){i_y[SB-1]}}, i_y};
                    r_count <= r_count + 1'b1;
                end else begin
                    r_ovf <= 1'b1;
                end
            end else if (r_run) begin
                if (r_add) begin
                    case (r_ph)
                        PH_XX:   r_sxx <= new_sum;
                        PH_YY:   r_syy <= new_sum;
                        default: r_sxy <= new_sum;
                    endcase
                end
                case (r_ph)
                    PH_XX:   r_ph <= PH_YY;
                    PH_YY:   r_ph <= PH_XY;
                    default: begin
                        r_ph   <= PH_XX;
                        r_run  <= 1'b0;
                        r_done <= 1'b1;
                    end
                endcase
            end
        end
    end

    assign o_done     = r_done;
    assign o_count    = r_count;
    assign o_sum_x    = r_sx;
    assign o_sum_y    = r_sy;
    assign o_sum_xx   = r_sxx;
    assign o_sum_yy   = r_syy;
    assign o_sum_xy   = r_sxy;
    assign o_overflow = r_ovf;

endmodule

>>> rtl/core/pc_finish.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pc_finish: coefficient sequencer
// Forms covariance and variance terms by shift-add multiplies, then finds
// the largest q with q^2*vx*vy <= 2^30*num^2 bit by bit, all on one adder.
// ----------------------------------------------------------------------------
module pc_finish import pc_pkg::*; #(
    parameter int CW  = 13,
    parameter int SXW = 29,
    parameter int SQW = 45,
    parameter int VW  = 57,
    parameter int PW  = 150
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_overflow,
    input  logic        [CW-1:0]  i_count,
    input  logic signed [SXW-1:0] i_sum_x,
    input  logic signed [SXW-1:0] i_sum_y,
    input  logic signed [SQW-1:0] i_sum_xx,
    input  logic signed [SQW-1:0] i_sum_yy,
    input  logic signed [SQW-1:0] i_sum_xy,
    output t_fin_result           o_res
);

    t_fin_state          r_state, n_state;
    t_job                r_job, n_job;
    logic [PW-1:0]       r_acc, n_acc, r_a, n_a, r_num, n_num, r_v, n_v, r_r, n_r;
    logic [PW-1:0]       r_t, n_t, r_d, n_d, r_v2k, n_v2k;
    logic [VW-1:0]       r_b, n_b, r_vx, n_vx, r_vy, n_vy;
    logic                r_neg, n_neg;
    logic [3:0]          r_k, n_k;
    logic [QBITS-1:0]    r_q, n_q;
    logic                r_done, n_done;
    logic [CORR_W-1:0]   r_corr, n_corr;
    logic [1:0]          r_status, n_status;

    // shared adder / subtractor
    logic [PW-1:0]       add_a, add_b;
    logic                add_sub;
    logic [PW:0]         add_res;

    logic [SXW-1:0]      mag_x, mag_y;
    logic [SQW-1:0]      mag_xx, mag_yy, mag_xy;
    logic [PW-1:0]       mag_num_w;
    logic [VW-1:0]       mag_num;
    logic [QBITS-1:0]    q_clip, corr_fin;

    assign add_res = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
                   + {{PW{1'b0}}, add_sub};

    always_comb begin
        mag_x     = i_sum_x[SXW-1]  ? (~i_sum_x + 1'b1)  : i_sum_x;
        mag_y     = i_sum_y[SXW-1]  ? (~i_sum_y + 1'b1)  : i_sum_y;
        mag_xx    = i_sum_xx[SQW-1] ? (~i_sum_xx + 1'b1) : i_sum_xx;
        mag_yy    = i_sum_yy[SQW-1] ? (~i_sum_yy + 1'b1) : i_sum_yy;
        mag_xy    = i_sum_xy[SQW-1] ? (~i_sum_xy + 1'b1) : i_sum_xy;
        mag_num_w = r_num[PW-1] ? (~r_num + 1'b1) : r_num;
        mag_num   = mag_num_w[VW-1:0];
        q_clip    = (r_q > Q_ONE) ? Q_ONE : r_q;
        if (r_num[PW-1]) begin
            corr_fin = ~q_clip + 1'b1;
        end else begin
            corr_fin = (q_clip > Q_MAX) ? Q_MAX : q_clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_job    <= n_job;
        r_acc    <= n_acc;
        r_a      <= n_a;
        r_b      <= n_b;
        r_neg    <= n_neg;
        r_num    <= n_num;
        r_vx     <= n_vx;
        r_vy     <= n_vy;
        r_v      <= n_v;
        r_r      <= n_r;
        r_t      <= n_t;
        r_d      <= n_d;
        r_v2k    <= n_v2k;
        r_k      <= n_k;
        r_q      <= n_q;
        r_corr   <= n_corr;
        r_status <= n_status;
    end

    always_comb begin
        n_state  = r_state;
        n_job    = r_job;
        n_acc    = r_acc;
        n_a      = r_a;
        n_b      = r_b;
        n_neg    = r_neg;
        n_num    = r_num;
        n_vx     = r_vx;
        n_vy     = r_vy;
        n_v      = r_v;
        n_r      = r_r;
        n_t      = r_t;
        n_d      = r_d;
        n_v2k    = r_v2k;
        n_k      = r_k;
        n_q      = r_q;
        n_done   = 1'b0;
        n_corr   = r_corr;
        n_status = r_status;
        add_a    = r_acc;
        add_b    = r_a;
        add_sub  = r_neg;

        case (r_state)
            F_IDLE: begin
                if (i_start) begin
                    n_job   = JOB_N_XY;
                    n_state = F_SETUP;
                end
            end

            F_SETUP: begin
                n_state = F_MUL;
                case (r_job)
                    JOB_N_XY: begin
                        n_acc = '0;
                        n_a   = PW'(i_count);
                        n_b   = VW'(mag_xy);
                        n_neg = i_sum_xy[SQW-1];
                    end
                    JOB_X_Y: begin
                        n_a   = PW'(mag_x);
                        n_b   = VW'(mag_y);
                        n_neg = ~(i_sum_x[SXW-1] ^ i_sum_y[SXW-1]);
                    end
                    JOB_N_XX: begin
                        n_acc = '0;
                        n_a   = PW'(i_count);
                        n_b   = VW'(mag_xx);
                        n_neg = i_sum_xx[SQW-1];
                    end
                    JOB_X_X: begin
                        n_a   = PW'(mag_x);
                        n_b   = VW'(mag_x);
                        n_neg = 1'b1;
                    end
                    JOB_N_YY: begin
                        n_acc = '0;
                        n_a   = PW'(i_count);
                        n_b   = VW'(mag_yy);
                        n_neg = i_sum_yy[SQW-1];
                    end
                    JOB_Y_Y: begin
                        n_a   = PW'(mag_y);
                        n_b   = VW'(mag_y);
                        n_neg = 1'b1;
                    end
                    JOB_VXY: begin
                        n_acc = '0;
                        n_a   = PW'(r_vx);
                        n_b   = r_vy;
                        n_neg = 1'b0;
                    end
                    default: begin
                        n_acc = '0;
                        n_a   = PW'(mag_num);
                        n_b   = mag_num;
                        n_neg = 1'b0;
                    end
                endcase
            end

            F_MUL: begin
                // one multiplier bit per cycle, early exit when no bits remain
                if (r_b == '0) begin
                    n_state = F_STORE;
                end else begin
                    if (r_b[0]) begin
                        n_acc = add_res[PW-1:0];
                    end
                    n_a = r_a << 1;
                    n_b = r_b >> 1;
                end
            end

            F_STORE: begin
                n_job   = t_job'(r_job + 3'd1);
                n_state = F_SETUP;
                case (r_job)
                    JOB_X_Y: n_num = r_acc;
                    JOB_X_X: n_vx  = r_acc[VW-1:0];
                    JOB_Y_Y: begin
                        n_vy = r_acc[VW-1:0];
                        if (i_overflow) begin
                            n_done   = 1'b1;
                            n_corr   = '0;
                            n_status = STATUS_TOO_LONG;
                            n_state  = F_IDLE;
                        end else if (r_vx == '0 || r_acc == '0) begin
                            n_done   = 1'b1;
                            n_corr   = '0;
                            n_status = STATUS_ZERO_VAR;
                            n_state  = F_IDLE;
                        end
                    end
                    JOB_VXY: n_v = r_acc;
                    JOB_NUM2: begin
                        n_r     = r_acc << (2 * QFRAC);
                        n_acc   = '0;
                        n_d     = '0;
                        n_v2k   = r_v << (2 * (QBITS - 1));
                        n_k     = 4'(QBITS - 1);
                        n_q     = '0;
                        n_state = F_SRCH0;
                    end
                    default: ;
                endcase
            end

            // candidate (q+2^k)^2*V = A + (qV << (k+1)) + (V << 2k)
            F_SRCH0: begin
                add_a   = r_acc;
                add_b   = r_d;
                add_sub = 1'b0;
                n_t     = add_res[PW-1:0];
                n_state = F_SRCH1;
            end

            F_SRCH1: begin
                add_a   = r_t;
                add_b   = r_v2k;
                add_sub = 1'b0;
                n_t     = add_res[PW-1:0];
                n_state = F_SRCH2;
            end

            F_SRCH2: begin
                add_a   = r_r;
                add_b   = r_t;
                add_sub = 1'b1;
                if (add_res[PW]) begin
                    n_acc    = r_t;
                    n_q[r_k] = 1'b1;
                    n_state  = F_SRCH3;
                end else if (r_k == '0) begin
                    n_done   = 1'b1;
                    n_corr   = corr_fin;
                    n_status = STATUS_OK;
                    n_state  = F_IDLE;
                end else begin
                    n_k     = r_k - 1'b1;
                    n_d     = r_d >> 1;
                    n_v2k   = r_v2k >> 2;
                    n_state = F_SRCH0;
                end
            end

            F_SRCH3: begin
                // qV grows by V << k, so qV << (k+1) grows by V << (2k+1)
                add_a   = r_d;
                add_b   = r_v2k << 1;
                add_sub = 1'b0;
                if (r_k == '0) begin
                    n_done   = 1'b1;
                    n_corr   = corr_fin;
                    n_status = STATUS_OK;
                    n_state  = F_IDLE;
                end else begin
                    n_k     = r_k - 1'b1;
                    n_d     = add_res[PW-1:0] >> 1;
                    n_v2k   = r_v2k >> 2;
                    n_state = F_SRCH0;
                end
            end

            default: n_state = F_IDLE;
        endcase
    end

    assign o_res = '{done: r_done, corr: r_corr, status: r_status};

endmodule

>>> rtl/core/pearson_correlation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pearson_correlation: streaming Pearson correlation coefficient
// Accumulates paired samples and emits r in Q1.15 on the last pair.
// ----------------------------------------------------------------------------
// A pair is taken when i_valid and o_ready are high; o_ready then stays low
// while its three products pass through the single multiplier, so a new
// pair is not taken until the last one is accumulated. The pair marked last
// adds the coefficient computation, which runs on one shared wide adder: up
// to eight shift-add multiplies, each stepping through the bits of its
// multiplier operand, followed by a 16-step root search. The result is held
// in an output register, so the next series may start while it waits.
// Status is 0 for a valid coefficient, 1 when either series has zero
// variance and 2 when more than MAX_SAMPLES pairs came.
module pearson_correlation import pc_pkg::*; #(
    parameter int MAX_SAMPLES = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_x_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_y_sample,
    input  logic                          i_last,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [CORR_W-1:0]      o_correlation,
    output logic        [1:0]             o_status
);

    localparam int CW  = $clog2(MAX_SAMPLES + 1);
    localparam int SXW = SAMPLE_BITS + CW;
    localparam int SQW = 2 * SAMPLE_BITS + CW;
    localparam int VW  = 2 * CW + 2 * SAMPLE_BITS - 1;
    localparam int PW  = 2 * VW + 2 * QBITS + 4;

    t_top_state               r_state, n_state;
    logic                     r_last, n_last;
    logic                     r_o_valid, n_o_valid;
    logic [CORR_W-1:0]        r_corr, n_corr;
    logic [1:0]               r_status, n_status;
    logic                     r_hold_vld, n_hold_vld;
    logic [CORR_W-1:0]        r_hold_corr, n_hold_corr;
    logic [1:0]               r_hold_status, n_hold_status;

    logic                     accept, acc_clear, fin_start;
    logic                     acc_done, acc_ovf;
    logic [CW-1:0]            acc_count;
    logic signed [SXW-1:0]    sum_x, sum_y;
    logic signed [SQW-1:0]    sum_xx, sum_yy, sum_xy;
    t_fin_result              fin_res;

    assign accept = i_valid && o_ready;

    pc_accum #(
        .SB          (SAMPLE_BITS),
        .CW          (CW),
        .SXW         (SXW),
        .SQW         (SQW),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_clear    (acc_clear),
        .i_x        (i_x_sample),
        .i_y        (i_y_sample),
        .o_done     (acc_done),
        .o_count    (acc_count),
        .o_sum_x    (sum_x),
        .o_sum_y    (sum_y),
        .o_sum_xx   (sum_xx),
        .o_sum_yy   (sum_yy),
        .o_sum_xy   (sum_xy),
        .o_overflow (acc_ovf)
    );

    pc_finish #(
        .CW  (CW),
        .SXW (SXW),
        .SQW (SQW),
        .VW  (VW),
        .PW  (PW)
    ) u_finish (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (fin_start),
        .i_overflow (acc_ovf),
        .i_count    (acc_count),
        .i_sum_x    (sum_x),
        .i_sum_y    (sum_y),
        .i_sum_xx   (sum_xx),
        .i_sum_yy   (sum_yy),
        .i_sum_xy   (sum_xy),
        .o_res      (fin_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= T_IDLE;
            r_o_valid  <= 1'b0;
            r_hold_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_o_valid  <= n_o_valid;
            r_hold_vld <= n_hold_vld;
        end
        r_last        <= n_last;
        r_corr        <= n_corr;
        r_status      <= n_status;
        r_hold_corr   <= n_hold_corr;
        r_hold_status <= n_hold_status;
    end

    always_comb begin
        n_state       = r_state;
        n_last        = r_last;
        n_corr        = r_corr;
        n_status      = r_status;
        n_hold_vld    = r_hold_vld;
        n_hold_corr   = r_hold_corr;
        n_hold_status = r_hold_status;
        n_o_valid     = r_o_valid && !i_ready;
        o_ready       = (r_state == T_IDLE);
        fin_start     = 1'b0;
        acc_clear     = 1'b0;

        case (r_state)
            T_IDLE: begin
                if (accept) begin
                    n_last  = i_last;
                    n_state = T_ACC;
                end
            end
            T_ACC: begin
                if (acc_done) begin
                    if (r_last) begin
                        fin_start = 1'b1;
                        n_state   = T_FIN;
                    end else begin
                        n_state = T_IDLE;
                    end
                end
            end
            T_FIN: begin
                if (fin_res.done) begin
                    n_hold_vld    = 1'b1;
                    n_hold_corr   = fin_res.corr;
                    n_hold_status = fin_res.status;
                    n_state       = T_OUT;
                end
            end
            T_OUT: begin
                // hand the result over once the output register is free
                if (!r_o_valid || i_ready) begin
                    n_o_valid  = 1'b1;
                    n_corr     = r_hold_corr;
                    n_status   = r_hold_status;
                    n_hold_vld = 1'b0;
                    acc_clear  = r_hold_vld;
                    n_state    = T_IDLE;
                end
            end
            default: n_state = T_IDLE;
        endcase
    end

    assign o_valid       = r_o_valid;
    assign o_correlation = r_corr;
    assign o_status      = r_status;

endmodule

>>> rtl/core/pc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pc_checker: port-level checks
// Watches the handshakes and result fields of the correlation core.
// ----------------------------------------------------------------------------
module pc_checker import pc_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic              i_last,
    input logic              o_valid,
    input logic              i_ready,
    input logic [CORR_W-1:0] o_correlation,
    input logic [1:0]        o_status
);

    // a stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_correlation) && $stable(o_status)))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == STATUS_OK || o_status == STATUS_ZERO_VAR ||
                     o_status == STATUS_TOO_LONG))
        else $error("undefined status code");

    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != STATUS_OK) |-> (o_correlation == '0))
        else $error("flagged result carries a nonzero coefficient");

    // accumulating a pair keeps the block busy, with o_ready low
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input taken on consecutive cycles");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && !i_last && !o_valid) |=> !o_valid)
        else $error("result produced by a pair that is not last");

endmodule

bind pearson_correlation pc_checker u_pc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .i_last        (i_last),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_correlation (o_correlation),
    .o_status      (o_status)
);

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: pearson_correlation self-checking bench
// Streams paired sample series through the block under random source gaps
// and sink stalls, predicts each coefficient and status exactly with wide
// integer arithmetic, and compares every result transaction in order.
// ----------------------------------------------------------------------------
module testbench;
    import pc_pkg::*;

    localparam int MAX_PAIRS = 4096;
    localparam int WIDE      = 200;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               last;
    } t_pair;

    typedef struct {
        logic signed [15:0] corr;
        logic [1:0]         status;
    } t_coef;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic signed [15:0] i_x_sample = '0;
    logic signed [15:0] i_y_sample = '0;
    logic               i_last = 1'b0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [15:0] o_correlation;
    logic [1:0]         o_status;

    t_pair pending_pairs[$];
    t_coef expected_coefs[$];
    bit    stimulus_done = 1'b0;
    int    fail_count = 0;
    int    coefs_seen = 0;

    // running sums, mirrored from accepted pairs
    int          pair_count = 0;
    longint      acc_x = 0, acc_y = 0, acc_xx = 0, acc_yy = 0, acc_xy = 0;
    bit          too_long = 1'b0;

    pearson_correlation u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_x_sample    (i_x_sample),
        .i_y_sample    (i_y_sample),
        .i_last        (i_last),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_correlation (o_correlation),
        .o_status      (o_status)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_coef compute_coefficient();
        t_coef                  res;
        logic signed [WIDE-1:0] n, sx, sy, num, vx, vy;
        logic [WIDE-1:0]        v, rhs, tt;
        int unsigned            q, t;
        bit                     neg;
        n   = pair_count;
        sx  = acc_x;
        sy  = acc_y;
        num = n * $signed(WIDE'(acc_xy)) - sx * sy;
        vx  = n * $signed(WIDE'(acc_xx)) - sx * sx;
        vy  = n * $signed(WIDE'(acc_yy)) - sy * sy;
        res.corr = '0;
        if (too_long) begin
            res.status = STATUS_TOO_LONG;
            return res;
        end
        if (vx == 0 || vy == 0) begin
            res.status = STATUS_ZERO_VAR;
            return res;
        end
        neg = num < 0;
        if (neg) num = -num;
        v   = vx * vy;
        rhs = (num * num) << 30;
        q   = 0;
        // largest q with q^2 * vx * vy <= 2^30 * num^2
        for (int b = 15; b >= 0; b--) begin
            t  = q | (32'd1 << b);
            tt = WIDE'(t) * WIDE'(t);
            if (tt * v <= rhs) q = t;
        end
        if (q > 32768) q = 32768;
        if (neg) res.corr = 16'(-int'(q));
        else res.corr = (q > 32767) ? Q_MAX : 16'(q);
        res.status = STATUS_OK;
        return res;
    endfunction

    function automatic void absorb_pair(t_pair p);
        longint x, y;
        x = p.x;
        y = p.y;
        if (pair_count < MAX_PAIRS) begin
            acc_x  += x;
            acc_y  += y;
            acc_xx += x * x;
            acc_yy += y * y;
            acc_xy += x * y;
            pair_count++;
        end else begin
            too_long = 1'b1;
        end
        if (p.last) begin
            expected_coefs.push_back(compute_coefficient());
            pair_count = 0;
            acc_x = 0; acc_y = 0; acc_xx = 0; acc_yy = 0; acc_xy = 0;
            too_long = 1'b0;
        end
    endfunction

    function automatic void add_pair(int x, int y, bit last);
        t_pair p;
        p.x = 16'(x);
        p.y = 16'(y);
        p.last = last;
        pending_pairs.push_back(p);
    endfunction

    // mode 0 random, 1 y tracks x, 2 y mirrors x, 3 constant x, 4 small values
    function automatic void add_series(int len, int mode);
        int x, y, k;
        k = $urandom_range(0, 65535) - 32768;
        for (int i = 0; i < len; i++) begin
            x = $urandom_range(0, 65535) - 32768;
            y = $urandom_range(0, 65535) - 32768;
            case (mode)
                1: y = x / 2 + int'($urandom_range(0, 15)) - 8;
                2: y = -x;
                3: x = k;
                4: begin
                    x = int'($urandom_range(0, 6)) - 3;
                    y = int'($urandom_range(0, 6)) - 3;
                end
                default: ;
            endcase
            add_pair(x, y, i == len - 1);
        end
    endfunction

    // sender: bursts and gaps
    int src_burst = 0;
    int src_gap = 0;
    always @(posedge i_clk) begin
        t_pair nxt;
        bit    offer;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                absorb_pair('{i_x_sample, i_y_sample, i_last});
            end
            if (!i_valid || o_ready) begin
                offer = 1'b0;
                if (src_gap > 0) begin
                    src_gap--;
                end else if (pending_pairs.size() > 0) begin
                    offer = 1'b1;
                    nxt = pending_pairs.pop_front();
                    if (src_burst > 0) begin
                        src_burst--;
                    end else begin
                        src_burst = $urandom_range(0, 40);
                        src_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                i_valid <= offer;
                if (offer) begin
                    i_x_sample <= nxt.x;
                    i_y_sample <= nxt.y;
                    i_last     <= nxt.last;
                end
            end
        end
    end

    // receiver stall pattern, with one long hold-off
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    int  stall_mode = 0;
    always @(posedge i_clk) begin
        if (!hold_done && coefs_seen == 20) begin
            hold_done = 1'b1;
            hold_left = 3000;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            if ($urandom_range(0, 255) == 0) stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: i_ready <= 1'b1;
                1: i_ready <= $urandom_range(0, 1);
                default: i_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_coef exp_c;
        if (i_rst_n && o_valid && i_ready) begin
            coefs_seen++;
            if (expected_coefs.size() == 0) begin
                $error("unexpected result transaction: correlation %0d status %0d",
                       o_correlation, o_status);
                fail_count++;
            end else begin
                exp_c = expected_coefs.pop_front();
                if (o_correlation !== exp_c.corr) begin
                    $error("correlation: expected %0d, actual %0d",
                           exp_c.corr, o_correlation);
                    fail_count++;
                end
                if (o_status !== exp_c.status) begin
                    $error("status: expected %0d, actual %0d", exp_c.status, o_status);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int m;
        // directed: single pair, extremes, full positive and negative, flat series
        add_pair(5, -7, 1'b1);
        add_pair(-32768, 32767, 1'b0);
        add_pair(32767, -32768, 1'b1);
        add_pair(-32768, -32768, 1'b0);
        add_pair(32767, 32767, 1'b0);
        add_pair(0, 0, 1'b1);
        add_pair(1, 3, 1'b0);
        add_pair(2, 3, 1'b0);
        add_pair(3, 3, 1'b1);
        add_pair(-1, 1, 1'b0);
        add_pair(-2, 2, 1'b0);
        add_pair(-32768, 32767, 1'b1);
        add_pair(1, 2, 1'b0);
        add_pair(2, 1, 1'b0);
        add_pair(3, 4, 1'b1);
        add_pair(0, 0, 1'b0);
        add_pair(0, 0, 1'b1);
        // random series, mostly short
        while (pending_pairs.size() < 1350) begin
            m = $urandom_range(0, 4);
            if ($urandom_range(0, 19) == 0) add_series($urandom_range(60, 200), m);
            else add_series($urandom_range(1, 24), m);
        end
        add_series(3, 0);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_pairs.size() == 0 && !i_valid);
        wait (expected_coefs.size() == 0);
        repeat (1000) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("pearson_correlation: match");
        end else begin
            $display("pearson_correlation: mismatch");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("pearson_correlation: mismatch");
        $finish;
    end

endmodule
